### sv/twss_pkg.sv
// ----------------------------------------------------------------------------
// twss_pkg
// Shared types and constants for the text word and sentence statistics block:
// opcodes, separator characters, field widths and the report slot record.
// ----------------------------------------------------------------------------
package twss_pkg;

   // Input opcodes.
   localparam logic OP_TEXT   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // Separator characters; the first three also close a sentence.
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_QUEST   = 8'h3F;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Widths of the result fields.
   localparam int OUT_W = 32;
   localparam int LEN_W = 8;
   localparam int POS_W = 6;

   localparam logic [LEN_W-1:0] LEN_MAX = 8'hFF;

   // One result of a report run as it travels down the read pipeline.
   typedef struct packed {
      logic [OUT_W-1:0] words;
      logic [OUT_W-1:0] sentences;
      logic [LEN_W-1:0] len;
      logic [POS_W-1:0] pos;
      logic             last;
      logic             empty;
   } slot_type;

endpackage

### sv/twss_ram.sv
// ----------------------------------------------------------------------------
// twss_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module twss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/text_word_sentence_stats.sv
// ----------------------------------------------------------------------------
// text_word_sentence_stats
// Word, sentence and longest-word statistics over a text byte stream.
// ----------------------------------------------------------------------------
// A text byte (opcode 0) is taken every cycle while no report run is reading,
// and produces no result; it updates the word and sentence counters and writes
// at most one character into a word buffer of 2*MAX_WORD bytes, split into two
// halves that swap between the current word and the longest word. A report
// (opcode 1) is taken and then holds req_stall high while the reads of its
// max(1, min(length, MAX_WORD)) results are issued, one character per cycle
// through the buffer's single read port while rsp_stall lets the reads go on.
// The first result of a report passes the sequencer, the read stage and the
// result register before it reaches the rsp_ port. The buffer needs no clearing
// after reset, since only characters already written are ever reported.
// ----------------------------------------------------------------------------
module text_word_sentence_stats #(
   parameter int MAX_WORD    = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_byte_value,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_words_seen,
   output logic [31:0] rsp_sentences_seen,
   output logic [7:0]  rsp_longest_length,
   output logic [7:0]  rsp_char_out,
   output logic [5:0]  rsp_char_position,
   output logic        rsp_last
);

   import twss_pkg::*;

   localparam int IDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int DEPTH  = 2 * MAX_WORD;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [LEN_W-1:0]       MAX_LEN  = LEN_W'(MAX_WORD);
   localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(MAX_WORD - 1);
   localparam logic [ADDR_W-1:0]      HALF_OFS = ADDR_W'(MAX_WORD);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

   // Text statistics state.
   logic                   in_word_ff,  in_word_in;
   logic                   in_sent_ff,  in_sent_in;
   logic [COUNT_WIDTH-1:0] word_tot_ff, word_tot_in;
   logic [COUNT_WIDTH-1:0] sent_tot_ff, sent_tot_in;
   logic [LEN_W-1:0]       cur_len_ff,  cur_len_in;
   logic [LEN_W-1:0]       best_len_ff, best_len_in;
   logic                   sel_ff,      sel_in;

   // Report sequencer.
   logic                   seq_active_ff,   seq_active_in;
   logic [IDX_W-1:0]       seq_idx_ff,      seq_idx_in;
   logic [IDX_W-1:0]       seq_last_idx_ff, seq_last_idx_in;
   logic                   seq_half_ff,     seq_half_in;
   slot_type               seq_meta_ff,     seq_meta_in;

   // Read data stage and result register.
   logic                   s2_valid_ff,  s2_valid_in;
   slot_type               s2_meta_ff,   s2_meta_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   slot_type               rsp_meta_ff,  rsp_meta_in;
   logic [7:0]             rsp_char_ff,  rsp_char_in;

   logic                   req_fire;
   logic                   text_fire;
   logic                   report_fire;
   logic                   is_sep;
   logic                   ends_sent;
   logic [LEN_W-1:0]       wr_pos;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [7:0]             rd_data;
   logic                   issue;
   logic                   issue_last;
   logic                   out_free;
   logic                   s2_free;
   logic                   use_cur;
   logic [LEN_W-1:0]       rep_len;
   logic [OUT_W-1:0]       words_out;
   logic [OUT_W-1:0]       sents_out;

   // Handshake: the input waits while a report run is still reading.
   assign req_stall   = seq_active_ff;
   assign req_fire    = req_valid && !req_stall;
   assign text_fire   = req_fire && (req_opcode == OP_TEXT);
   assign report_fire = req_fire && (req_opcode == OP_REPORT);

   // Character classes.
   assign is_sep    = req_byte_value inside {CHAR_BANG, CHAR_QUEST, CHAR_DOT,
                                             CHAR_COMMA, CHAR_SPACE, CHAR_NEWLINE};
   assign ends_sent = req_byte_value inside {CHAR_BANG, CHAR_QUEST, CHAR_DOT};

   // Buffer write: characters past MAX_WORD are dropped.
   assign wr_pos  = in_word_ff ? cur_len_ff : '0;
   assign wr_en   = text_fire && !is_sep && (wr_pos < MAX_LEN);
   assign wr_addr = sel_ff ? HALF_OFS + ADDR_W'(wr_pos[IDX_W-1:0])
                           : ADDR_W'(wr_pos[IDX_W-1:0]);

   // Counters as seen on the 32-bit result fields.
   generate
      if (COUNT_WIDTH >= OUT_W) begin : g_cnt_trunc
         assign words_out = word_tot_ff[OUT_W-1:0];
         assign sents_out = sent_tot_ff[OUT_W-1:0];
      end else begin : g_cnt_ext
         assign words_out = {{(OUT_W-COUNT_WIDTH){1'b0}}, word_tot_ff};
         assign sents_out = {{(OUT_W-COUNT_WIDTH){1'b0}}, sent_tot_ff};
      end
   endgenerate

   // Text byte update of counters, flags and the buffer halves.
   always_comb begin
      in_word_in  = in_word_ff;
      in_sent_in  = in_sent_ff;
      word_tot_in = word_tot_ff;
      sent_tot_in = sent_tot_ff;
      cur_len_in  = cur_len_ff;
      best_len_in = best_len_ff;
      sel_in      = sel_ff;
      if (text_fire) begin
         if (is_sep) begin
            // A finished word longer than the best takes over its half.
            if (in_word_ff && (cur_len_ff > best_len_ff)) begin
               best_len_in = cur_len_ff;
               sel_in      = !sel_ff;
            end
            if (ends_sent) begin
               in_sent_in = 1'b0;
            end
            in_word_in = 1'b0;
            cur_len_in = '0;
         end else if (!in_word_ff) begin
            in_word_in  = 1'b1;
            word_tot_in = (word_tot_ff == CNT_MAX) ? word_tot_ff : word_tot_ff + 1'b1;
            cur_len_in  = LEN_W'(1);
            if (!in_sent_ff) begin
               sent_tot_in = (sent_tot_ff == CNT_MAX) ? sent_tot_ff : sent_tot_ff + 1'b1;
            end
            in_sent_in = 1'b1;
         end else if (cur_len_ff != LEN_MAX) begin
            cur_len_in = cur_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff  <= 1'b0;
         in_sent_ff  <= 1'b0;
         word_tot_ff <= '0;
         sent_tot_ff <= '0;
         cur_len_ff  <= '0;
         best_len_ff <= '0;
         sel_ff      <= 1'b0;
      end else begin
         in_word_ff  <= in_word_in;
         in_sent_ff  <= in_sent_in;
         word_tot_ff <= word_tot_in;
         sent_tot_ff <= sent_tot_in;
         cur_len_ff  <= cur_len_in;
         best_len_ff <= best_len_in;
         sel_ff      <= sel_in;
      end
   end

   // Report choice: a word in progress wins if it is longer than the best.
   assign use_cur = in_word_ff && (cur_len_ff > best_len_ff);
   assign rep_len = use_cur ? cur_len_ff : best_len_ff;

   // Pipeline flow: the result register frees the read stage.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || out_free;
   assign issue      = seq_active_ff && s2_free;
   assign issue_last = seq_meta_ff.empty || (seq_idx_ff == seq_last_idx_ff);
   assign rd_addr    = seq_half_ff ? HALF_OFS + ADDR_W'(seq_idx_ff)
                                   : ADDR_W'(seq_idx_ff);

   // Sequencer: snapshot on a report, then one buffer read per cycle while the read stage is free.
   always_comb begin
      seq_active_in   = seq_active_ff;
      seq_idx_in      = seq_idx_ff;
      seq_last_idx_in = seq_last_idx_ff;
      seq_half_in     = seq_half_ff;
      seq_meta_in     = seq_meta_ff;
      if (report_fire) begin
         seq_active_in         = 1'b1;
         seq_idx_in            = '0;
         seq_last_idx_in       = (rep_len >= MAX_LEN) ? LAST_IDX
                                                      : IDX_W'(rep_len - 1'b1);
         seq_half_in           = use_cur ? sel_ff : !sel_ff;
         seq_meta_in.words     = words_out;
         seq_meta_in.sentences = sents_out;
         seq_meta_in.len       = rep_len;
         seq_meta_in.pos       = '0;
         seq_meta_in.last      = 1'b0;
         seq_meta_in.empty     = (rep_len == '0);
      end else if (issue) begin
         if (issue_last) begin
            seq_active_in = 1'b0;
         end else begin
            seq_idx_in = seq_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
      end else begin
         seq_active_ff <= seq_active_in;
      end
      seq_idx_ff      <= seq_idx_in;
      seq_last_idx_ff <= seq_last_idx_in;
      seq_half_ff     <= seq_half_in;
      seq_meta_ff     <= seq_meta_in;
   end

   // Word buffer holding both ping-pong halves.
   twss_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte_value),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read stage: slot details line up with the RAM read data.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_meta_in  = s2_meta_ff;
      if (s2_free) begin
         s2_valid_in     = issue;
         s2_meta_in      = seq_meta_ff;
         s2_meta_in.pos  = POS_W'(seq_idx_ff);
         s2_meta_in.last = issue_last;
      end
   end

   // Result register: the character is forced to zero for an empty report.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_meta_in  = rsp_meta_ff;
      rsp_char_in  = rsp_char_ff;
      if (out_free) begin
         rsp_valid_in = s2_valid_ff;
         rsp_meta_in  = s2_meta_ff;
         rsp_char_in  = s2_meta_ff.empty ? 8'h00 : rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s2_meta_ff  <= s2_meta_in;
      rsp_meta_ff <= rsp_meta_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_words_seen     = rsp_meta_ff.words;
   assign rsp_sentences_seen = rsp_meta_ff.sentences;
   assign rsp_longest_length = rsp_meta_ff.len;
   assign rsp_char_out       = rsp_char_ff;
   assign rsp_char_position  = rsp_meta_ff.pos;
   assign rsp_last           = rsp_meta_ff.last;

endmodule

### sv/twss_checker.sv
// ----------------------------------------------------------------------------
// twss_checker
// Port-level checks for the text word and sentence statistics block, bound
// to every instance of the top level.
// ----------------------------------------------------------------------------
module twss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_words_seen,
   input logic [31:0] rsp_sentences_seen,
   input logic [7:0]  rsp_longest_length,
   input logic [7:0]  rsp_char_out,
   input logic [5:0]  rsp_char_position,
   input logic        rsp_last
);

   // A stalled result stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its fields.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_words_seen) && $stable(rsp_sentences_seen)
         && $stable(rsp_longest_length) && $stable(rsp_char_out)
         && $stable(rsp_char_position) && $stable(rsp_last))
      else $error("stalled result changed");

   // Results of one report run come without gaps.
   a_run_dense : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a report run");

   // Within a run the position steps by one and the summary stays fixed.
   a_run_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         (rsp_char_position == $past(rsp_char_position) + 6'd1)
         && (rsp_longest_length == $past(rsp_longest_length))
         && (rsp_words_seen == $past(rsp_words_seen))
         && (rsp_sentences_seen == $past(rsp_sentences_seen)))
      else $error("report run out of order");

   // A report without a word is a single zero result.
   a_empty_report : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_longest_length == 8'd0) |->
         rsp_last && (rsp_char_out == 8'd0) && (rsp_char_position == 6'd0))
      else $error("malformed empty report");

endmodule

bind text_word_sentence_stats twss_checker u_twss_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_words_seen     (rsp_words_seen),
   .rsp_sentences_seen (rsp_sentences_seen),
   .rsp_longest_length (rsp_longest_length),
   .rsp_char_out       (rsp_char_out),
   .rsp_char_position  (rsp_char_position),
   .rsp_last           (rsp_last)
);
